FILE: sv/fc_pkg.sv
package fc_pkg;

	// number of cells in the delay line chain
	localparam int CELLS = 4;
	localparam int CELL_BITS = $clog2(CELLS);

	// defaults for the top level parameters
	localparam int MAX_TAPS_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int OP_BITS = 2;
	localparam int IDX_BITS = 10;
	localparam int CFG_BITS = 11;

	// request kinds carried on s_tuser
	localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_BITS-1:0] OP_PUSH = 2'd1;
	localparam logic [OP_BITS-1:0] OP_FLUSH = 2'd2;

	// cycles between the last tap read and a settled accumulator
	localparam int DRAIN_CYC = 2;
	localparam int STEP_BITS = $clog2(CELLS) + 1;

	// per-cycle commands from the sequencer to every cell
	typedef struct packed {
		logic hist_clr;
		logic hist_rd;
		logic hist_wr;
		logic mac_en;
		logic acc_clr;
		logic sum_en;
	} cell_ctl_t;

endpackage

FILE: sv/fc_ram.sv
module fc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/fc_cell.sv
module fc_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int AW = 8,
	parameter int CELL_ID = 0,
	parameter int ACC_W = 42,
	parameter int TAPS_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fc_pkg::cell_ctl_t       ctl,
	input  logic [AW-1:0]           ptr,
	input  logic [AW-1:0]           j,
	input  logic [TAPS_W-1:0]       taps_eff,
	input  logic                    coef_we,
	input  logic [AW-1:0]           coef_waddr,
	input  logic [SAMPLE_BITS-1:0]  coef_wdata,
	input  logic [SAMPLE_BITS-1:0]  samp_in,
	output logic [SAMPLE_BITS-1:0]  samp_out,
	input  logic signed [ACC_W-1:0] sum_in,
	output logic signed [ACC_W-1:0] sum_out
);

	localparam int DEPTH = 1 << AW;
	localparam int CW = fc_pkg::CELL_BITS;

	logic                          hist_we;
	logic [AW-1:0]                 hist_waddr;
	logic [SAMPLE_BITS-1:0]        hist_wdata;
	logic                          hist_re;
	logic [AW-1:0]                 hist_raddr;
	logic [SAMPLE_BITS-1:0]        hist_rdata;
	logic [SAMPLE_BITS-1:0]        coef_rdata;
	logic                          tap_active;
	logic                          act_s1;
	logic                          act_s2;
	logic signed [2*SAMPLE_BITS-1:0] prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       sum_q;

	// history port: clear sweep, evict read and write at ptr, tap reads behind ptr
	assign hist_we    = ctl.hist_clr | ctl.hist_wr;
	assign hist_waddr = ctl.hist_clr ? j : ptr;
	assign hist_wdata = ctl.hist_clr ? '0 : samp_in;
	assign hist_re    = ctl.hist_rd | ctl.mac_en;
	assign hist_raddr = ctl.mac_en ? (ptr - j) : ptr;

	fc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	fc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.re    (ctl.mac_en),
		.raddr (j),
		.rdata (coef_rdata)
	);

	// oldest sample of this cell feeds the next cell
	assign samp_out = hist_rdata;

	// global tap number of this read against the tap count
	assign tap_active = {1'b0, CW'(CELL_ID), j} < taps_eff;

	// tap enable follows the ram read and the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= ctl.mac_en & tap_active;
			act_s2 <= act_s1;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(coef_rdata) * $signed(hist_rdata);
	end

	// local accumulator and the partial sum handed down the chain
	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (act_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (ctl.sum_en) begin
			sum_q <= acc_q + sum_in;
		end
	end

	assign sum_out = sum_q;

endmodule

FILE: sv/fir_convolution.sv
// channel  dir  signals                          contents (lowest bit up)
// s        in   s_tvalid s_tready s_tdata s_tuser tdata: tap_index, value; tuser: op
// m        out  m_tvalid m_tready m_tdata m_tuser tdata: out_sample; tuser: saturated
// cfg      in   cfg_valid cfg_ready cfg_data      tap_count
//
// m_tvalid rises after a push or flush request is accepted and the sequencer has run read,
// write, the tap loop over D rows (D = per-cell depth, 256 at defaults), drain and sum; the tap loop does one
// multiply-accumulate per cell per cycle, then the partial sums ripple down the chain
// a load request writes its coefficient as it is accepted, op 3 is accepted and dropped
// after reset the history rams are swept clear with s_tready low
// the next request is taken while a result waits on m; a stalled m holds the
// finished sum until it drains
module fir_convolution #(
	parameter int MAX_TAPS = fc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fc_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W = ((fc_pkg::IDX_BITS + SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [IN_W-1:0]             s_tdata,  // tap_index, value
	input  logic [fc_pkg::OP_BITS-1:0]  s_tuser,  // op
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_W-1:0]            m_tdata,  // out_sample
	output logic [0:0]                  m_tuser,  // saturated
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fc_pkg::CFG_BITS-1:0] cfg_data
);

	localparam int CELLS = fc_pkg::CELLS;
	localparam int CW = fc_pkg::CELL_BITS;
	localparam int PER_CELL = (MAX_TAPS + CELLS - 1) / CELLS;
	localparam int AW = (PER_CELL <= 2) ? 1 : $clog2(PER_CELL);
	localparam int TAPS_W = AW + CW + 1;
	localparam int ACC_W = 2 * SAMPLE_BITS + AW + CW;
	localparam int FRAC = SAMPLE_BITS - 1;
	localparam int SB = SAMPLE_BITS;
	localparam int STW = fc_pkg::STEP_BITS;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);
	localparam logic signed [ACC_W-1:0] OUT_HI = (ACC_W'(1) <<< FRAC) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] OUT_LO = -(ACC_W'(1) <<< FRAC);
	localparam logic [AW-1:0] J_LAST = '1;
	localparam logic [STW-1:0] DRAIN_LAST = STW'(fc_pkg::DRAIN_CYC - 1);
	localparam logic [STW-1:0] SUM_LAST = STW'(CELLS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_MAC   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_SUM   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]                  state_q;
	logic [AW-1:0]               j_q;
	logic [AW-1:0]               ptr_q;
	logic [STW-1:0]              step_q;
	logic [SB-1:0]               sample_q;
	logic [fc_pkg::CFG_BITS-1:0] tap_count_q;
	logic                        m_valid_q;
	logic [SB-1:0]               out_q;
	logic                        sat_q;

	logic [fc_pkg::OP_BITS-1:0]  op;
	logic [fc_pkg::IDX_BITS-1:0] tap_index;
	logic [SB-1:0]               value;
	logic                        accept;
	logic                        idx_ok;
	logic [AW+CW-1:0]            idx_wide;
	logic [CW-1:0]               coef_sel;
	logic [TAPS_W-1:0]           taps_eff;
	fc_pkg::cell_ctl_t           ctl;
	logic                        out_free;
	logic signed [ACC_W-1:0]     sum_fin;
	logic signed [ACC_W-1:0]     rnd;
	logic                        sat_hi;
	logic                        sat_lo;
	logic [SB-1:0]               out_d;

	logic [SB-1:0]               samp_chain [CELLS+1];
	logic signed [ACC_W-1:0]     sum_chain [CELLS+1];

	// request fields
	assign op        = s_tuser;
	assign tap_index = s_tdata[fc_pkg::IDX_BITS-1:0];
	assign value     = s_tdata[fc_pkg::IDX_BITS +: SB];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	// coefficient load address split into cell and row
	assign idx_ok   = 32'(tap_index) < 32'(MAX_TAPS);
	assign idx_wide = (AW + CW)'(tap_index);
	assign coef_sel = idx_wide[AW+CW-1 -: CW];

	// tap count limited to the store size
	assign taps_eff = (32'(tap_count_q) > 32'(MAX_TAPS)) ? TAPS_W'(MAX_TAPS)
		: TAPS_W'(tap_count_q);

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fc_pkg::CFG_BITS'(1);
		end else if (cfg_valid & cfg_ready) begin
			tap_count_q <= cfg_data;
		end
	end

	// cell commands by state
	always_comb begin
		ctl          = '0;
		ctl.hist_clr = (state_q == ST_CLEAR);
		ctl.hist_rd  = (state_q == ST_READ);
		ctl.hist_wr  = (state_q == ST_WRITE);
		ctl.acc_clr  = (state_q == ST_WRITE);
		ctl.mac_en   = (state_q == ST_MAC);
		ctl.sum_en   = (state_q == ST_SUM);
	end

	// the chain: samples move on at write, partial sums at sum
	assign samp_chain[0] = sample_q;
	assign sum_chain[0]  = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		logic coef_we;
		assign coef_we = accept & (op == fc_pkg::OP_LOAD) & idx_ok
			& (coef_sel == CW'(k));
		fc_cell #(
			.SAMPLE_BITS (SB),
			.AW          (AW),
			.CELL_ID     (k),
			.ACC_W       (ACC_W),
			.TAPS_W      (TAPS_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ptr        (ptr_q),
			.j          (j_q),
			.taps_eff   (taps_eff),
			.coef_we    (coef_we),
			.coef_waddr (idx_wide[AW-1:0]),
			.coef_wdata (value),
			.samp_in    (samp_chain[k]),
			.samp_out   (samp_chain[k+1]),
			.sum_in     (sum_chain[k]),
			.sum_out    (sum_chain[k+1])
		);
	end

	// round half up and clip to the sample range
	assign sum_fin = sum_chain[CELLS];
	assign rnd     = (sum_fin + HALF) >>> FRAC;
	assign sat_hi  = rnd > OUT_HI;
	assign sat_lo  = rnd < OUT_LO;
	assign out_d   = sat_hi ? OUT_HI[SB-1:0] : (sat_lo ? OUT_LO[SB-1:0] : rnd[SB-1:0]);

	assign out_free = ~m_valid_q | m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			j_q     <= '0;
			ptr_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					j_q <= j_q + AW'(1);
					if (j_q == J_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (op == fc_pkg::OP_PUSH || op == fc_pkg::OP_FLUSH)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					j_q <= j_q + AW'(1);
					if (j_q == J_LAST) begin
						ptr_q   <= ptr_q + AW'(1);
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					step_q <= step_q + STW'(1);
					if (step_q == DRAIN_LAST) begin
						step_q  <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					step_q <= step_q + STW'(1);
					if (step_q == SUM_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// new sample, zero for a flush
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= (op == fc_pkg::OP_PUSH) ? value : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= out_d;
			sat_q <= sat_hi | sat_lo;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = OUT_W'(out_q);
	assign m_tuser[0] = sat_q;

`ifndef SYNTH
	// coefficients are only written between requests
	a_coef_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == fc_pkg::OP_LOAD) |-> (state_q == ST_IDLE))
		else $error("coefficient write outside idle");

	// a clipped result sits at one of the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && sat_q) |-> (out_q == OUT_HI[SB-1:0] || out_q == OUT_LO[SB-1:0]))
		else $error("saturated flag on an unclipped value");

	// history pointer moves once per sample, at the end of the tap loop
	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_MAC && j_q == J_LAST) |=> $stable(ptr_q))
		else $error("history pointer moved outside the tap loop");

	// a finished sum reaches the output register and frees the sequencer
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_valid_q && state_q == ST_IDLE))
		else $error("result not delivered to the output register");
`endif

endmodule
